// File: design/mcp_pkg.sv
// ----------------------------------------------------------------------------
// mcp_pkg: shared types and constants for the congruence product block
// Widths, operation codes, register indexes, transaction structs and the
// Q16.16 narrowing function used by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mcp_pkg;

  // matrix geometry and number format
  localparam int MAX_DIM   = 8;
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int DIM_W     = 4;
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  // one product is 2*DATA_W bits, MAX_DIM of them need log2(MAX_DIM) more
  localparam int ACC_W     = 2 * DATA_W + $clog2(MAX_DIM);

  // operation codes
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_LOAD_X = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_C = 2'd1;
  localparam logic [OP_W-1:0] OP_START  = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 4'd1;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // input transaction
  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [DATA_W-1:0] element_value;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [DATA_W-1:0] out_value;
    logic                     last;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic             load_x;
    logic             load_c;
    logic             issue;
    logic             phase2;
    logic             first;
    logic             last;
    logic             final_elem;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
  } mcp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pipe_busy;
  } mcp_status_t;

  // control tag that travels with each multiply-accumulate
  typedef struct packed {
    logic             valid;
    logic             phase2;
    logic             first;
    logic             last;
    logic             final_elem;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
  } mcp_tag_t;

  // arithmetic shift by FRAC_BITS, then saturate to DATA_W signed
  function automatic logic [DATA_W-1:0] sat_narrow(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] sh;
    logic [ACC_W-DATA_W:0]   top;
    sh  = a >>> FRAC_BITS;
    top = sh[ACC_W-1:DATA_W-1];
    if ((&top) || !(|top)) begin
      return sh[DATA_W-1:0];
    end
    return a[ACC_W-1] ? SAT_MIN : SAT_MAX;
  endfunction

endpackage

`default_nettype wire

// File: design/mcp_ram.sv
// ----------------------------------------------------------------------------
// mcp_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mcp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/mcp_ctrl.sv
// ----------------------------------------------------------------------------
// mcp_ctrl: sequencer for the congruence product
// Decodes input transactions, walks the i/j/k loops of T = X^T C and
// S = T X, and waits for the datapath to drain after each phase.
// ----------------------------------------------------------------------------
`default_nettype none

module mcp_ctrl import mcp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [OP_W-1:0] op_i,
  input  wire logic [DIM_W-1:0] rows_i,
  input  wire logic [DIM_W-1:0] cols_i,
  input  wire mcp_status_t status_i,
  output      logic        busy_o,
  output      mcp_cmd_t    cmd_o
);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [ST_W-1:0] ST_PH1    = 3'd1;
  localparam logic [ST_W-1:0] ST_DRAIN1 = 3'd2;
  localparam logic [ST_W-1:0] ST_PH2    = 3'd3;
  localparam logic [ST_W-1:0] ST_DRAIN2 = 3'd4;

  logic [ST_W-1:0]  state_q, state_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [DIM_W-1:0] n_dim, m_dim, j_dim;
  logic             k_last, j_last, i_last;

  // zero acts as one, anything above MAX_DIM acts as MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
    if (r == '0) begin
      return DIM_W'(1);
    end
    if (r > DIM_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  assign n_dim  = eff_dim(rows_i);
  assign m_dim  = eff_dim(cols_i);
  assign j_dim  = (state_q == ST_PH2) ? m_dim : n_dim;
  assign k_last = ({1'b0, k_q} == n_dim - DIM_W'(1));
  assign j_last = ({1'b0, j_q} == j_dim - DIM_W'(1));
  assign i_last = ({1'b0, i_q} == m_dim - DIM_W'(1));

  // next state and commands
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    cmd_o   = '0;
    cmd_o.i = i_q;
    cmd_o.j = j_q;
    cmd_o.k = k_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (op_i)
            OP_LOAD_X: cmd_o.load_x = 1'b1;
            OP_LOAD_C: cmd_o.load_c = 1'b1;
            OP_START: begin
              i_d     = '0;
              j_d     = '0;
              k_d     = '0;
              state_d = ST_PH1;
            end
            default: ;
          endcase
        end
      end
      ST_PH1, ST_PH2: begin
        cmd_o.issue      = 1'b1;
        cmd_o.phase2     = (state_q == ST_PH2);
        cmd_o.first      = (k_q == '0);
        cmd_o.last       = k_last;
        cmd_o.final_elem = (state_q == ST_PH2) && i_last && j_last;
        if (!k_last) begin
          k_d = k_q + IDX_W'(1);
        end else begin
          k_d = '0;
          if (!j_last) begin
            j_d = j_q + IDX_W'(1);
          end else begin
            j_d = '0;
            if (!i_last) begin
              i_d = i_q + IDX_W'(1);
            end else begin
              i_d     = '0;
              state_d = (state_q == ST_PH1) ? ST_DRAIN1 : ST_DRAIN2;
            end
          end
        end
      end
      ST_DRAIN1: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_PH2;
        end
      end
      ST_DRAIN2: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and loop counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// File: design/mcp_dpath.sv
// ----------------------------------------------------------------------------
// mcp_dpath: storage and multiply-accumulate pipeline
// Holds X, C and T in RAMs and runs one shared MAC: read, multiply,
// accumulate, narrow. T goes back to its RAM, S goes to the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module mcp_dpath import mcp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire mcp_cmd_t    cmd_i,
  input  wire in_item_t    in_i,
  output      mcp_status_t status_o,
  output      logic        out_valid_o,
  output      out_item_t   out_o
);

  logic [ADDR_W-1:0] load_addr, x_raddr, c_raddr, p_raddr, p_waddr;
  logic [DATA_W-1:0] x_rdata, c_rdata, p_rdata;

  mcp_tag_t s1_q, s2_q, s3_q;

  logic signed [DATA_W-1:0]   op_a, op_b;
  logic signed [2*DATA_W-1:0] prod_q;
  logic signed [ACC_W-1:0]    acc_q, acc_d;

  logic              s4_valid_q, s4_phase2_q, s4_final_q;
  logic [IDX_W-1:0]  s4_i_q, s4_j_q;
  logic [DATA_W-1:0] s4_value_q;

  // addresses are row * MAX_DIM + col
  assign load_addr = {in_i.row_index, in_i.col_index};
  assign x_raddr   = cmd_i.phase2 ? {cmd_i.k, cmd_i.j} : {cmd_i.k, cmd_i.i};
  assign c_raddr   = {cmd_i.k, cmd_i.j};
  assign p_raddr   = {cmd_i.i, cmd_i.k};
  assign p_waddr   = {s4_i_q, s4_j_q};

  mcp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_x),
    .waddr_i (load_addr),
    .wdata_i (in_i.element_value),
    .raddr_i (x_raddr),
    .rdata_o (x_rdata)
  );

  mcp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_c_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_c),
    .waddr_i (load_addr),
    .wdata_i (in_i.element_value),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  mcp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_p_ram (
    .clk_i   (clk_i),
    .we_i    (s4_valid_q && !s4_phase2_q),
    .waddr_i (p_waddr),
    .wdata_i (s4_value_q),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  // operand select: X^T C in the first phase, T X in the second
  assign op_a = s1_q.phase2 ? p_rdata : x_rdata;
  assign op_b = s1_q.phase2 ? x_rdata : c_rdata;

  // accumulate at full width
  assign acc_d = s2_q.first ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);

  // control tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q       <= '0;
      s2_q       <= '0;
      s3_q       <= '0;
      s4_valid_q <= 1'b0;
    end else begin
      s1_q.valid      <= cmd_i.issue;
      s1_q.phase2     <= cmd_i.phase2;
      s1_q.first      <= cmd_i.first;
      s1_q.last       <= cmd_i.last;
      s1_q.final_elem <= cmd_i.final_elem;
      s1_q.i          <= cmd_i.i;
      s1_q.j          <= cmd_i.j;
      s2_q            <= s1_q;
      s3_q            <= s2_q;
      s4_valid_q      <= s3_q.valid && s3_q.last;
    end
  end

  // multiply and accumulate registers
  always_ff @(posedge clk_i) begin
    if (s1_q.valid) begin
      prod_q <= op_a * op_b;
    end
    if (s2_q.valid) begin
      acc_q <= acc_d;
    end
  end

  // narrowed element, written back as T or shown as S
  always_ff @(posedge clk_i) begin
    if (s3_q.valid && s3_q.last) begin
      s4_phase2_q <= s3_q.phase2;
      s4_final_q  <= s3_q.final_elem;
      s4_i_q      <= s3_q.i;
      s4_j_q      <= s3_q.j;
      s4_value_q  <= sat_narrow(acc_q);
    end
  end

  assign status_o.pipe_busy = s1_q.valid || s2_q.valid || s3_q.valid || s4_valid_q;

  assign out_valid_o       = s4_valid_q && s4_phase2_q;
  assign out_o.out_row     = s4_i_q;
  assign out_o.out_col     = s4_j_q;
  assign out_o.out_value   = s4_value_q;
  assign out_o.last        = s4_final_q;

endmodule

`default_nettype wire

// File: design/matrix_congruence_product.sv
// ----------------------------------------------------------------------------
// matrix_congruence_product: S = X^T C X in signed Q16.16
// Top level with configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction on the input side is taken when start_i is high and busy_o
//   is low. op OP_LOAD_X / OP_LOAD_C writes one element of X or C and gives
//   no result. OP_START computes S (m x m, m = cols_in_use, n = rows_in_use)
//   and keeps busy_o high until the last element is out.
//   Results appear row-major, one per out_valid_o strobe, each for one cycle;
//   the receiver cannot stall and must take every strobe. out_o.last marks
//   the final element.
//   Timing: one shared multiply-accumulate unit with a four-stage pipeline
//   (RAM read, multiply, accumulate, narrow) does one product per cycle
//   while a phase runs. Phase one does m*n*n products, phase two m*m*n,
//   each followed by a drain of the pipeline.
//   Configuration: rows_in_use (CFG_ROWS) and cols_in_use (CFG_COLS) reset
//   to 8 and are written by the user while busy_o is low (not enforced).
//   Reset clears control state; element stores are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_congruence_product import mcp_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output      logic                 busy_o,
  input  wire in_item_t             in_i,
  output      logic                 out_valid_o,
  output      out_item_t            out_o,
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DIM_W-1:0]     cfg_data_i
);

  logic [DIM_W-1:0] rows_q, cols_q;
  mcp_cmd_t         cmd;
  mcp_status_t      status;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DIM_RESET;
      cols_q <= DIM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ROWS: rows_q <= cfg_data_i;
        CFG_COLS: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mcp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .op_i     (in_i.op),
    .rows_i   (rows_q),
    .cols_i   (cols_q),
    .status_i (status),
    .busy_o   (busy_o),
    .cmd_o    (cmd)
  );

  mcp_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_i        (in_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

  // results only come out during a computation
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> busy_o)
    else $error("result strobe while idle");

  // an accepted transaction never yields a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> !out_valid_o)
    else $error("result right after an accepted transaction");

  // nothing follows the final element; busy drops once the drain state sees the pipe empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.last) |=> !out_valid_o ##1 $fell(busy_o))
    else $error("activity after the final element");

endmodule

`default_nettype wire
